### rtl/i2p_pkg.sv
// Shared types, character codes and the operator rank table of the infix to
// postfix converter. No dependencies; used by every other RTL file.
`default_nettype none

package i2p_pkg;

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChOpen    = 8'h28;
  localparam logic [7:0] ChClose   = 8'h29;
  localparam logic [7:0] ChMul     = 8'h2A;
  localparam logic [7:0] ChDiv     = 8'h2F;
  localparam logic [7:0] ChMod     = 8'h25;
  localparam logic [7:0] ChAdd     = 8'h2B;
  localparam logic [7:0] ChSub     = 8'h2D;
  localparam logic [7:0] ChAnd     = 8'h26;
  localparam logic [7:0] ChXor     = 8'h5E;
  localparam logic [7:0] ChOr      = 8'h7C;

  // Precedence ranks. Brackets rank below every operator, operands above.
  localparam logic [2:0] RankBracket = 3'd0;
  localparam logic [2:0] RankOr      = 3'd1;
  localparam logic [2:0] RankXor     = 3'd2;
  localparam logic [2:0] RankAnd     = 3'd3;
  localparam logic [2:0] RankAddSub  = 3'd4;
  localparam logic [2:0] RankMulDiv  = 3'd5;
  localparam logic [2:0] RankOperand = 3'd6;

  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_NEWLINE,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OPER,
    CLS_OTHER
  } char_cls_e;

  typedef enum logic [1:0] {
    EMIT_CHAR,
    EMIT_TOP,
    EMIT_SPACE,
    EMIT_NEWLINE
  } emit_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LINE_POP,
    ST_LINE_SPACE,
    ST_CLOSE_POP,
    ST_CLOSE_SPACE,
    ST_OPER_POP,
    ST_OPER_SPACE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load_char;
    logic      emit;
    emit_sel_e emit_sel;
    logic      emit_last;
    logic      push;
    logic      pop;
    logic      set_in_op;
    logic      clr_in_op;
    logic      clr_ovf;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    char_cls_e cls;
    logic      in_op;
    logic      empty;
    logic      top_open;
    logic      top_pops;
    logic      emit_ok;
  } sts_t;

  function automatic logic [2:0] op_rank(input logic [7:0] ch);
    logic [2:0] r;
    case (ch)
      ChMul, ChDiv, ChMod: r = RankMulDiv;
      ChAdd, ChSub:        r = RankAddSub;
      ChAnd:               r = RankAnd;
      ChXor:               r = RankXor;
      ChOr:                r = RankOr;
      ChOpen, ChClose:     r = RankBracket;
      default:             r = RankOperand;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/infix_to_postfix_converter.sv
// Top level of the infix to postfix converter: joins the controller and the
// datapath to the stream ports. Depends on i2p_pkg, i2p_ctrl and i2p_dp.
//
// Usage: characters of an infix expression enter on the s_axis channel, one
// byte per transaction, and the postfix text leaves on the m_axis channel,
// one byte per transaction. Operators are reordered by precedence through an
// operator stack of StackDepth entries; a newline flushes the stack and ends
// the line. tlast marks the final output byte caused by one input byte, and
// tuser carries the sticky overflow flag of the current line, which is set
// when a push onto a full stack was dropped.
//
// Sequencing: a character occupies the block from acceptance until its last
// output byte is in the output register and its last stack step is done. A
// newline passes through accept, dispatch, then the final newline byte.
// Outside an operand, an operator or a closing bracket passes through accept,
// dispatch, then the push or the bracket match. Any other character passes
// through accept, then dispatch. Each entry popped and emitted from the stack
// adds itself and its trailing space, as the single output register takes one
// byte per cycle while the receiver keeps up; an opening bracket discarded by
// a closing bracket adds nothing. Output bytes are registered and appear in
// the cycle after they form. The block takes one character at a time.
//
// Reset clears the stack count, the operand flag, the overflow flag and the
// output valid flag; the stack storage and the output data are not cleared.
// When the receiver holds tready low, the output register keeps its byte and
// the controller waits in place; nothing is lost or repeated.
`default_nettype none

module infix_to_postfix_converter #(
  parameter int StackDepth = 31
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] char_in
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] char_out
  output logic            m_axis_tlast_o,   // last_of_run
  output logic            m_axis_tuser_o    // [0] overflow_seen
);
  import i2p_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing of dispatch, pops and line flushes.
  i2p_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_vld_i (s_axis_tvalid_i),
    .in_rdy_o (s_axis_tready_o),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  // Stack, flags and the output register that parts the two channels.
  i2p_dp #(
    .StackDepth (StackDepth)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .char_i     (s_axis_tdata_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_vld_o  (m_axis_tvalid_o),
    .out_rdy_i  (m_axis_tready_i),
    .out_char_o (m_axis_tdata_o),
    .out_last_o (m_axis_tlast_o),
    .out_ovf_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

### rtl/i2p_dp.sv
// Datapath of the infix to postfix converter: character register, operator
// stack, line flags and the output register. Depends on i2p_pkg.
`default_nettype none

module i2p_dp #(
  parameter int StackDepth = 31
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    char_i,
  input  wire i2p_pkg::cmd_t cmd_i,
  output i2p_pkg::sts_t      sts_o,
  output logic               out_vld_o,
  input  wire logic          out_rdy_i,
  output logic [7:0]         out_char_o,
  output logic               out_last_o,
  output logic               out_ovf_o
);
  import i2p_pkg::*;

  localparam int CntW = $clog2(StackDepth + 1);
  localparam int IdxW = $clog2(StackDepth);

  logic [7:0]      char_q;
  logic [7:0]      stack_q [StackDepth];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] top_pos;
  logic [7:0]      top;
  logic            full;
  logic            in_op_q, in_op_d;
  logic            ovf_q, ovf_d;
  logic            out_vld_q;
  logic [7:0]      out_char_q;
  logic            out_last_q;
  logic            out_ovf_q;
  logic [7:0]      emit_char;
  logic            emit_ok;
  char_cls_e       cls;

  assign top_pos = cnt_q - CntW'(1);
  assign top     = stack_q[top_pos[IdxW-1:0]];
  assign full    = (cnt_q == CntW'(StackDepth));
  assign emit_ok = !out_vld_q || out_rdy_i;

  always_comb begin
    case (char_q)
      ChSpace:   cls = CLS_SPACE;
      ChNewline: cls = CLS_NEWLINE;
      ChOpen:    cls = CLS_OPEN;
      ChClose:   cls = CLS_CLOSE;
      default:   cls = (op_rank(char_q) == RankOperand) ? CLS_OTHER : CLS_OPER;
    endcase
  end

  always_comb begin
    sts_o.cls      = cls;
    sts_o.in_op    = in_op_q;
    sts_o.empty    = (cnt_q == '0);
    sts_o.top_open = (top == ChOpen);
    sts_o.top_pops = (cnt_q != '0) && (op_rank(top) >= op_rank(char_q));
    sts_o.emit_ok  = emit_ok;
  end

  always_comb begin
    case (cmd_i.emit_sel)
      EMIT_CHAR:  emit_char = char_q;
      EMIT_TOP:   emit_char = top;
      EMIT_SPACE: emit_char = ChSpace;
      default:    emit_char = ChNewline;
    endcase
  end

  always_comb begin
    cnt_d   = cnt_q;
    in_op_d = in_op_q;
    ovf_d   = ovf_q;
    if (cmd_i.pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
    if (cmd_i.push) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
    if (cmd_i.set_in_op) begin
      in_op_d = 1'b1;
    end
    if (cmd_i.clr_in_op) begin
      in_op_d = 1'b0;
    end
    if (cmd_i.clr_ovf) begin
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      in_op_q   <= 1'b0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      in_op_q <= in_op_d;
      ovf_q   <= ovf_d;
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (out_rdy_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_char) begin
      char_q <= char_i;
    end
    if (cmd_i.push && !full) begin
      stack_q[cnt_q[IdxW-1:0]] <= char_q;
    end
    if (cmd_i.emit) begin
      out_char_q <= emit_char;
      out_last_q <= cmd_i.emit_last;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_vld_o  = out_vld_q;
  assign out_char_o = out_char_q;
  assign out_last_o = out_last_q;
  assign out_ovf_o  = out_ovf_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(StackDepth))
    else $error("operator stack count beyond depth");

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> emit_ok)
    else $error("result written over a result not yet taken");

  a_nl_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.emit_sel == EMIT_NEWLINE) |=> (!ovf_q && cnt_q == '0))
    else $error("line end left overflow flag or stack entries");

endmodule

`default_nettype wire

### rtl/i2p_ctrl.sv
// Controller state machine of the infix to postfix converter: sequences
// dispatch, stack pops and line flushes. Depends on i2p_pkg.
`default_nettype none

module i2p_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_vld_i,
  output logic               in_rdy_o,
  input  wire i2p_pkg::sts_t sts_i,
  output i2p_pkg::cmd_t      cmd_o
);
  import i2p_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_vld_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (sts_i.in_op) begin
          if (sts_i.emit_ok) begin
            state_d = (sts_i.cls == CLS_NEWLINE) ? ST_LINE_POP : ST_IDLE;
          end
        end else begin
          case (sts_i.cls)
            CLS_NEWLINE: state_d = ST_LINE_POP;
            CLS_CLOSE:   state_d = ST_CLOSE_POP;
            CLS_OPER:    state_d = ST_OPER_POP;
            CLS_OTHER:   state_d = sts_i.emit_ok ? ST_IDLE : ST_DISPATCH;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_LINE_POP: begin
        if (sts_i.emit_ok) state_d = sts_i.empty ? ST_IDLE : ST_LINE_SPACE;
      end
      ST_LINE_SPACE: begin
        if (sts_i.emit_ok) state_d = ST_LINE_POP;
      end
      ST_CLOSE_POP: begin
        if (sts_i.empty || sts_i.top_open) begin
          state_d = ST_IDLE;
        end else if (sts_i.emit_ok) begin
          state_d = ST_CLOSE_SPACE;
        end
      end
      ST_CLOSE_SPACE: begin
        if (sts_i.emit_ok) state_d = ST_CLOSE_POP;
      end
      ST_OPER_POP: begin
        if (!sts_i.top_pops) begin
          state_d = ST_IDLE;
        end else if (sts_i.emit_ok) begin
          state_d = ST_OPER_SPACE;
        end
      end
      ST_OPER_SPACE: begin
        if (sts_i.emit_ok) state_d = ST_OPER_POP;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o    = '0;
    in_rdy_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_rdy_o        = 1'b1;
        cmd_o.load_char = in_vld_i;
      end
      ST_DISPATCH: begin
        if (sts_i.in_op) begin
          if (sts_i.emit_ok) begin
            cmd_o.emit = 1'b1;
            case (sts_i.cls)
              CLS_SPACE: begin
                cmd_o.emit_sel  = EMIT_SPACE;
                cmd_o.emit_last = 1'b1;
                cmd_o.clr_in_op = 1'b1;
              end
              CLS_NEWLINE: begin
                cmd_o.emit_sel  = EMIT_SPACE;
                cmd_o.clr_in_op = 1'b1;
              end
              default: begin
                cmd_o.emit_sel  = EMIT_CHAR;
                cmd_o.emit_last = 1'b1;
              end
            endcase
          end
        end else begin
          case (sts_i.cls)
            CLS_OPEN: cmd_o.push = 1'b1;
            CLS_OTHER: begin
              if (sts_i.emit_ok) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_sel  = EMIT_CHAR;
                cmd_o.emit_last = 1'b1;
                cmd_o.set_in_op = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LINE_POP: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          if (sts_i.empty) begin
            cmd_o.emit_sel  = EMIT_NEWLINE;
            cmd_o.emit_last = 1'b1;
            cmd_o.clr_ovf   = 1'b1;
          end else begin
            cmd_o.emit_sel = EMIT_TOP;
            cmd_o.pop      = 1'b1;
          end
        end
      end
      ST_LINE_SPACE: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EMIT_SPACE;
        end
      end
      ST_CLOSE_POP: begin
        if (!sts_i.empty) begin
          if (sts_i.top_open) begin
            cmd_o.pop = 1'b1;
          end else if (sts_i.emit_ok) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = EMIT_TOP;
            cmd_o.pop      = 1'b1;
          end
        end
      end
      ST_CLOSE_SPACE: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = EMIT_SPACE;
          cmd_o.emit_last = sts_i.empty || sts_i.top_open;
        end
      end
      ST_OPER_POP: begin
        if (!sts_i.top_pops) begin
          cmd_o.push = 1'b1;
        end else if (sts_i.emit_ok) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EMIT_TOP;
          cmd_o.pop      = 1'b1;
        end
      end
      ST_OPER_SPACE: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = EMIT_SPACE;
          cmd_o.emit_last = !sts_i.top_pops;
        end
      end
      default: ;
    endcase
  end

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_i && in_rdy_o) |=> (state_q == ST_DISPATCH))
    else $error("accepted character not dispatched");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |-> (!sts_i.empty && !cmd_o.push))
    else $error("pop on empty stack or together with a push");

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench of the infix to postfix converter: character
// stimulus on the input stream, postfix bytes checked on the output stream.
// Depends on i2p_pkg and the converter RTL only.
`timescale 1ns / 1ps

module tb;
  import i2p_pkg::*;

  localparam int STACK_DEPTH = 31;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_CHARS = 125;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       ovf;
  } postfix_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tready = 1'b0;
  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tlast_o;
  logic       m_axis_tuser_o;

  // Expected output bytes, oldest first, and the predictor's own state.
  postfix_beat_t postfix_q[$];
  logic [7:0]    step_bytes[$];
  logic [7:0]    op_stack[STACK_DEPTH];
  int unsigned   op_count = 0;
  logic          in_word = 1'b0;
  logic          ovf_flag = 1'b0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        hold_req = 1'b0;
  logic        rx_hold = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  int unsigned chars_sent = 0;
  int unsigned bytes_checked = 0;
  int unsigned ovf_lines = 0;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  infix_to_postfix_converter #(
    .StackDepth(STACK_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),          // [7:0] char_in
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),   // [7:0] char_out
    .m_axis_tlast_o (m_axis_tlast_o),   // last_of_run
    .m_axis_tuser_o (m_axis_tuser_o)    // [0] overflow_seen
  );

  // ---------------------------------------------------------------- predictor

  function automatic logic [2:0] prec_of(input logic [7:0] c);
    case (c)
      ChMul, ChDiv, ChMod: return RankMulDiv;
      ChAdd, ChSub:        return RankAddSub;
      ChAnd:               return RankAnd;
      ChXor:               return RankXor;
      ChOr:                return RankOr;
      ChOpen, ChClose:     return RankBracket;
      default:             return RankOperand;
    endcase
  endfunction

  function automatic void push_op(input logic [7:0] c);
    if (op_count >= STACK_DEPTH) begin
      ovf_flag = 1'b1;
    end else begin
      op_stack[op_count] = c;
      op_count++;
    end
  endfunction

  function automatic void pop_op();
    op_count--;
    step_bytes.push_back(op_stack[op_count]);
    step_bytes.push_back(ChSpace);
  endfunction

  // Line end empties the stack, opening brackets too, then closes the line.
  function automatic void flush_line();
    while (op_count > 0) pop_op();
    step_bytes.push_back(ChNewline);
  endfunction

  function automatic void predict_postfix(input logic [7:0] c);
    logic line_done;
    line_done = 1'b0;
    step_bytes.delete();
    if (in_word) begin
      if (c == ChSpace) begin
        step_bytes.push_back(ChSpace);
        in_word = 1'b0;
      end else if (c == ChNewline) begin
        step_bytes.push_back(ChSpace);
        in_word = 1'b0;
        flush_line();
        line_done = 1'b1;
      end else begin
        step_bytes.push_back(c);
      end
    end else if (c == ChSpace) begin
      // Spaces between tokens produce nothing.
    end else if (c == ChNewline) begin
      flush_line();
      line_done = 1'b1;
    end else if (c == ChOpen) begin
      push_op(c);
    end else if (c == ChClose) begin
      while (op_count > 0 && op_stack[op_count - 1] != ChOpen) pop_op();
      if (op_count > 0) op_count--;
    end else if (prec_of(c) == RankOperand) begin
      in_word = 1'b1;
      step_bytes.push_back(c);
    end else begin
      while (op_count > 0 && prec_of(op_stack[op_count - 1]) >= prec_of(c)) pop_op();
      push_op(c);
    end
    // The overflow flag shown is the one after this character, before a
    // newline clears it.
    foreach (step_bytes[k]) begin
      postfix_q.push_back('{ch: step_bytes[k], last: (k == step_bytes.size() - 1),
                            ovf: ovf_flag});
    end
    if (line_done) begin
      if (ovf_flag) ovf_lines++;
      ovf_flag = 1'b0;
      op_count = 0;
    end
  endfunction

  // ------------------------------------------------------- output side

  // Long receiver hold-off, counted here so that the sender keeps offering.
  initial begin : rx_hold_proc
    forever begin
      wait (hold_req);
      @(posedge clk_i);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      rx_hold <= 1'b0;
      hold_req = 1'b0;
    end
  end

  always @(posedge clk_i) begin : postfix_checker
    postfix_beat_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (postfix_q.size() == 0) begin
        $error("unexpected output transaction: char_out %h", m_axis_tdata_o);
        errors++;
      end else begin
        want = postfix_q.pop_front();
        if (m_axis_tdata_o !== want.ch) begin
          $error("char_out: expected %h, got %h", want.ch, m_axis_tdata_o);
          errors++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last_of_run: expected %b, got %b", want.last, m_axis_tlast_o);
          errors++;
        end
        if (m_axis_tuser_o !== want.ovf) begin
          $error("overflow_seen: expected %b, got %b", want.ovf, m_axis_tuser_o);
          errors++;
        end
        bytes_checked++;
      end
    end
    m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected",
               cycle_count, postfix_q.size());
      $display("tb failed");
      $finish;
    end
  end

  // ------------------------------------------------------- input side

  // Offers one character, idling first at random, and returns at the edge
  // that completes the transaction. Valid stays high for a following call.
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_postfix(c);
    chars_sent++;
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_char(text[i]);
  endtask

  // Sender pauses until every expected byte is out and the block has settled.
  task automatic wait_postfix_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (postfix_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] special_char(input int unsigned idx);
    case (idx)
      0:       return ChMul;
      1:       return ChDiv;
      2:       return ChMod;
      3:       return ChAdd;
      4:       return ChSub;
      5:       return ChAnd;
      6:       return ChXor;
      7:       return ChOr;
      8:       return ChOpen;
      9:       return ChClose;
      10:      return ChSpace;
      default: return ChNewline;
    endcase
  endfunction

  // An operand starts with a byte that is no operator or bracket; later bytes
  // may be anything but a space or newline, operators and brackets included.
  task automatic send_operand();
    logic [7:0] c;
    int unsigned extra;
    do begin
      c = ($urandom_range(99) < 70) ? 8'(8'h61 + $urandom_range(25)) : 8'($urandom);
    end while (prec_of(c) != RankOperand || c == ChSpace || c == ChNewline);
    send_char(c);
    extra = $urandom_range(2);
    repeat (extra) begin
      do begin
        c = ($urandom_range(99) < 85) ? 8'(8'h30 + $urandom_range(9)) : 8'($urandom);
      end while (c == ChSpace || c == ChNewline);
      send_char(c);
    end
  endtask

  // Mostly well-formed expressions with random shape, some noise lines and a
  // few deep bracket runs that can reach the stack limit.
  task automatic send_random_line();
    int unsigned depth;
    int unsigned terms;
    int unsigned max_terms;
    int unsigned n;
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        send_char(($urandom_range(1) == 1) ? special_char($urandom_range(11))
                                           : 8'($urandom));
      end
      send_char(ChNewline);
    end else begin
      if ($urandom_range(99) < 5) begin
        n = $urandom_range(25, 34);
        repeat (n) send_char(ChOpen);
      end
      max_terms = $urandom_range(1, 6);
      terms = 0;
      depth = 0;
      forever begin
        while (depth < 4 && $urandom_range(99) < 25) begin
          send_char(ChOpen);
          depth++;
          if ($urandom_range(3) == 0) send_char(ChSpace);
        end
        send_operand();
        terms++;
        if (terms >= max_terms) begin
          if ($urandom_range(1) == 1) begin
            send_char(ChSpace);
            while (depth > 0 && $urandom_range(9) != 0) begin
              send_char(ChClose);
              depth--;
            end
          end
          send_char(ChNewline);
          break;
        end
        send_char(ChSpace);
        while (depth > 0 && $urandom_range(99) < 35) begin
          send_char(ChClose);
          depth--;
        end
        send_char(special_char($urandom_range(7)));
        if ($urandom_range(1) == 1) send_char(ChSpace);
      end
    end
  endtask

  // ------------------------------------------------------- tests

  task automatic test_precedence_and_brackets();
    send_text("a *(b -c )%d /e +f &g ^h |i\n");
  endtask

  // Extreme bytes as operand characters, a bracket echoed inside an operand,
  // a closing bracket on an empty stack and a newline ending an operand.
  task automatic test_edge_bytes();
    send_char(8'hFF);
    send_char(ChClose);
    send_char(ChSpace);
    send_char(ChClose);
    send_char(8'h00);
    send_char(ChNewline);
  endtask

  // Fills the stack, drops an operator push and a bracket push on the full
  // stack, then ends the line inside an operand for the longest output run.
  task automatic test_stack_overflow();
    repeat (STACK_DEPTH - 1) send_char(ChOpen);
    send_char(ChOr);
    send_char(ChXor);
    send_char(ChOpen);
    send_char(8'h78);
    send_char(ChNewline);
    send_char(ChClose);
  endtask

  task automatic test_random_text(input int unsigned n_chars);
    int unsigned stop_at;
    stop_at = chars_sent + n_chars;
    while (chars_sent < stop_at) send_random_line();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 24;
    rx_idle_pct = 73;
    test_precedence_and_brackets();
    test_edge_bytes();
    wait_postfix_drained();
    test_stack_overflow();
    wait_postfix_drained();
    test_random_text(RANDOM_CHARS);
    wait_postfix_drained();

    tx_idle_pct = 73;
    rx_idle_pct = 24;
    test_random_text(RANDOM_CHARS);
    wait_postfix_drained();

    // No idling; the long hold-off backs the block up into its input.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    test_random_text(RANDOM_CHARS);
    wait_postfix_drained();

    $display("%0d characters sent, %0d postfix bytes checked, %0d lines with overflow",
             chars_sent, bytes_checked, ovf_lines);
    if (errors == 0 && postfix_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
